// ----- hdl/mrq_pkg.sv -----
// Package for the message ring queue: field widths, reset values,
// operation, status, register and controller state codes.
// No dependencies.
package mrq_pkg;

  // Default sizing, handed to the top level parameters
  localparam int SLOTS_DEF     = 16;
  localparam int MAX_BYTES_DEF = 64;

  // Fixed field widths
  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int CAP_W  = 5;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 7;
  localparam int CIDX_W = 1;

  // Register reset values
  localparam int CAP_RESET   = 16;
  localparam int LIMIT_RESET = 64;

  typedef enum logic [OP_W-1:0] {
    OP_SEND       = 2'd0,
    OP_SEND_DROP  = 2'd1,
    OP_SEND_FRONT = 2'd2,
    OP_RECV       = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_TOO_LONG = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_CAPACITY  = 1'b0,
    REG_MAX_BYTES = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_LEN    = 2'd1,
    S_STREAM = 2'd2,
    S_COPY   = 2'd3
  } state_t;

endpackage

// ----- hdl/mrq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read. No dependencies.
module mrq_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/message_ring_queue.sv -----
// Message ring queue top level: controller, index registers and the three
// memories (staging, slot lengths, slot bytes).
// Depends on mrq_pkg and mrq_ram.
//
//  channel   direction  handshake               payload
//  op        in         op_valid / op_stall     operation data_byte byte_last requested_size
//  res       out        res_valid / res_stall   out_byte byte_valid run_last status delivered_size
//  cfg       in         cfg_valid / cfg_ready   cfg_index cfg_data
//
// The last send byte commits; an accepted message is then copied from staging
// into its slot through the staging read port, with the op channel stalled.
// A receive first reads the slot length, then streams one byte per cycle
// through the slot byte read port. Result stalls hold the stream without
// losing a byte.
// Reset is synchronous and clears control state only; the memories need no
// clearing since no entry is read before it is written.
module message_ring_queue
  import mrq_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int MAX_BYTES = MAX_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // op channel
  input  logic              op_valid,
  output logic              op_stall,
  input  logic [OP_W-1:0]   operation,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              byte_last,
  input  logic [LEN_W-1:0]  requested_size,
  // result channel
  output logic              res_valid,
  input  logic              res_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              byte_valid,
  output logic              run_last,
  output logic [STAT_W-1:0] status,
  output logic [LEN_W-1:0]  delivered_size,
  // configuration channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int SB_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int SB_DEPTH = 1 << (IDX_W + SB_W);
  localparam int CAP_INIT = (CAP_RESET > SLOTS) ? SLOTS : CAP_RESET;
  localparam int LIM_INIT = (LIMIT_RESET > MAX_BYTES) ? MAX_BYTES : LIMIT_RESET;

  // Controller state
  state_t state, state_next;

  // Ring registers
  logic [IDX_W-1:0] wr_idx, rd_idx, cap_last;
  logic [CNT_W-1:0] count;
  logic [LEN_W-1:0] lim;

  // Send staging
  logic             sending, too_long;
  op_t              kind;
  logic [LEN_W-1:0] staged;

  // Receive stream
  logic [IDX_W-1:0] rx_slot;
  logic [LEN_W-1:0] rx_req, rx_n, rx_cnt;
  logic             rx_pend, rx_pend_last;

  // Copy sweep
  logic [IDX_W-1:0] cp_slot;
  logic [LEN_W-1:0] cp_len, cp_cnt;
  logic             cp_wr_valid;
  logic [SB_W-1:0]  cp_wr_off;

  // Memory read data
  logic [BYTE_W-1:0] stg_rd_data, sb_rd_data;
  logic [LEN_W-1:0]  len_rd_data;

  // Control
  logic             out_free, accept, is_recv, is_byte, commit, commit_ok, full;
  logic             fits, tl_new, rx_issue, rx_move, cp_issue, cp_done, len_zero;
  logic             load;
  op_t              op_in, kind_cur;
  logic [LEN_W-1:0] cnt_cur, cnt_new, len_n, req_sat;
  logic             tl_cur;
  status_t          commit_status;
  logic [IDX_W-1:0] slot_tgt, rd_inc, rd_dec, wr_inc, ri_commit, wi_commit;
  logic [CNT_W-1:0] count_commit;

  // Result register inputs
  logic [BYTE_W-1:0] ld_byte;
  logic              ld_valid;
  status_t           ld_status;
  logic [LEN_W-1:0]  ld_size;

  assign op_in     = op_t'(operation);
  assign cfg_ready = 1'b1;
  assign out_free  = !res_valid || !res_stall;

  // Ring index arithmetic
  assign rd_inc = (rd_idx == cap_last) ? '0 : rd_idx + IDX_W'(1);
  assign rd_dec = (rd_idx == '0) ? cap_last : rd_idx - IDX_W'(1);
  assign wr_inc = (wr_idx == cap_last) ? '0 : wr_idx + IDX_W'(1);
  assign full   = count > CNT_W'(cap_last);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (is_recv && count != '0) begin
          state_next = S_LEN;
        end else if (commit && commit_ok) begin
          state_next = S_COPY;
        end
      end
      S_LEN: begin
        if (!len_zero) begin
          state_next = S_STREAM;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_STREAM: begin
        if (rx_move && rx_pend_last) begin
          state_next = S_IDLE;
        end
      end
      S_COPY: begin
        if (cp_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake and datapath strobes
  always_comb begin
    op_stall = !(state == S_IDLE && out_free);
    accept   = op_valid && !op_stall;
    is_recv  = accept && !sending && op_in == OP_RECV;
    is_byte  = accept && !(!sending && op_in == OP_RECV);
    commit   = is_byte && byte_last;

    // staging view for this byte
    cnt_cur  = sending ? staged : '0;
    tl_cur   = sending ? too_long : 1'b0;
    kind_cur = sending ? kind : op_in;
    fits     = cnt_cur < lim;
    cnt_new  = fits ? cnt_cur + LEN_W'(1) : cnt_cur;
    tl_new   = tl_cur || !fits;

    // commit decision
    commit_ok = !tl_new && (!full || kind_cur == OP_SEND_DROP);
    if (tl_new) begin
      commit_status = STAT_TOO_LONG;
    end else if (!commit_ok) begin
      commit_status = STAT_FULL;
    end else begin
      commit_status = STAT_OK;
    end
    ri_commit    = rd_idx;
    wi_commit    = wr_idx;
    count_commit = count + CNT_W'(1);
    slot_tgt     = wr_idx;
    if (kind_cur == OP_SEND_FRONT) begin
      ri_commit = rd_dec;
      slot_tgt  = rd_dec;
    end else begin
      wi_commit = wr_inc;
      if (full) begin
        // drop the oldest message first
        ri_commit    = rd_inc;
        count_commit = count;
      end
    end

    // receive
    req_sat  = (int'(requested_size) > MAX_BYTES) ? LEN_W'(MAX_BYTES) : requested_size;
    len_n    = (len_rd_data < rx_req) ? len_rd_data : rx_req;
    len_zero = len_n == '0;
    rx_move  = state == S_STREAM && rx_pend && out_free;
    rx_issue = state == S_STREAM && rx_cnt < rx_n && (!rx_pend || rx_move);

    // copy sweep
    cp_issue = state == S_COPY && cp_cnt < cp_len;
    cp_done  = state == S_COPY && cp_cnt == cp_len && !cp_wr_valid;
  end

  // Result register load
  always_comb begin
    load      = 1'b0;
    ld_byte   = '0;
    ld_valid  = 1'b0;
    ld_status = STAT_OK;
    ld_size   = '0;
    if (is_recv && count == '0) begin
      load      = 1'b1;
      ld_status = STAT_EMPTY;
    end else if (commit) begin
      load      = 1'b1;
      ld_status = commit_status;
    end else if (state == S_LEN && len_zero && out_free) begin
      load = 1'b1;
    end else if (rx_move) begin
      load     = 1'b1;
      ld_byte  = sb_rd_data;
      ld_valid = 1'b1;
      ld_size  = rx_n;
    end
  end

  // Result register; run_last is set on every result except inner stream bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
    if (load) begin
      out_byte       <= ld_byte;
      byte_valid     <= ld_valid;
      run_last       <= rx_move ? rx_pend_last : 1'b1;
      status         <= ld_status;
      delivered_size <= ld_size;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wr_idx      <= '0;
      rd_idx      <= '0;
      count       <= '0;
      cap_last    <= IDX_W'(CAP_INIT - 1);
      lim         <= LEN_W'(LIM_INIT);
      sending     <= 1'b0;
      too_long    <= 1'b0;
      kind        <= OP_SEND;
      staged      <= '0;
      rx_pend     <= 1'b0;
      cp_wr_valid <= 1'b0;
    end else begin
      state <= state_next;

      // send bytes and commit
      if (is_byte) begin
        if (byte_last) begin
          sending  <= 1'b0;
          staged   <= '0;
          too_long <= 1'b0;
          kind     <= OP_SEND;
          if (commit_ok) begin
            rd_idx <= ri_commit;
            wr_idx <= wi_commit;
            count  <= count_commit;
          end
        end else begin
          sending  <= 1'b1;
          staged   <= cnt_new;
          too_long <= tl_new;
          kind     <= kind_cur;
        end
      end

      // receive takes the oldest message off the ring at once
      if (is_recv && count != '0) begin
        rd_idx <= rd_inc;
        count  <= count - CNT_W'(1);
      end

      // stream read stage
      if (rx_issue) begin
        rx_pend <= 1'b1;
      end else if (rx_move) begin
        rx_pend <= 1'b0;
      end

      cp_wr_valid <= cp_issue;

      // configuration; a capacity write empties the ring
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_CAPACITY: begin
            wr_idx <= '0;
            rd_idx <= '0;
            count  <= '0;
            if (cfg_data[CAP_W-1:0] == '0) begin
              cap_last <= '0;
            end else if (int'(cfg_data[CAP_W-1:0]) > SLOTS) begin
              cap_last <= IDX_W'(SLOTS - 1);
            end else begin
              cap_last <= IDX_W'(cfg_data[CAP_W-1:0] - CAP_W'(1));
            end
          end
          REG_MAX_BYTES: begin
            lim <= (int'(cfg_data) > MAX_BYTES) ? LEN_W'(MAX_BYTES) : cfg_data;
          end
          default: ;
        endcase
      end
    end
  end

  // Payload registers of the receive and copy sequencers
  always_ff @(posedge clk) begin
    if (is_recv) begin
      rx_slot <= rd_idx;
      rx_req  <= req_sat;
    end
    if (state == S_LEN) begin
      rx_n   <= len_n;
      rx_cnt <= '0;
    end else if (rx_issue) begin
      rx_cnt <= rx_cnt + LEN_W'(1);
    end
    if (rx_issue) begin
      rx_pend_last <= (rx_cnt + LEN_W'(1)) == rx_n;
    end
    if (commit) begin
      cp_slot <= slot_tgt;
      cp_len  <= cnt_new;
      cp_cnt  <= '0;
    end else if (cp_issue) begin
      cp_cnt <= cp_cnt + LEN_W'(1);
    end
    cp_wr_off <= cp_cnt[SB_W-1:0];
  end

  // Staging buffer: filled by send bytes, swept out by the copy
  mrq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_BYTES)
  ) u_staging (
    .clk     (clk),
    .wr_en   (is_byte && fits),
    .wr_addr (cnt_cur[SB_W-1:0]),
    .wr_data (data_byte),
    .rd_en   (cp_issue),
    .rd_addr (cp_cnt[SB_W-1:0]),
    .rd_data (stg_rd_data)
  );

  // Slot lengths: written at commit, read at receive
  mrq_ram #(
    .WIDTH (LEN_W),
    .DEPTH (SLOTS)
  ) u_slot_len (
    .clk     (clk),
    .wr_en   (commit && commit_ok),
    .wr_addr (slot_tgt),
    .wr_data (cnt_new),
    .rd_en   (is_recv && count != '0),
    .rd_addr (rd_idx),
    .rd_data (len_rd_data)
  );

  // Slot bytes, addressed by slot and byte offset
  mrq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (SB_DEPTH)
  ) u_slot_bytes (
    .clk     (clk),
    .wr_en   (cp_wr_valid),
    .wr_addr ({cp_slot, cp_wr_off}),
    .wr_data (stg_rd_data),
    .rd_en   (rx_issue),
    .rd_addr ({rx_slot, rx_cnt[SB_W-1:0]}),
    .rd_data (sb_rd_data)
  );

endmodule
